// ===== rtl/mcsh_pkg.sv =====
// Shared constants for the moving circle versus moving segment hit test.
// No dependencies; used by the channel interfaces, the core and the checker.
package mcsh_pkg;

   localparam int COORD_BITS_DEFAULT      = 24;
   localparam int PARAM_FRAC_BITS_DEFAULT = 16;

   localparam int RADIUS_WIDTH   = 16;
   localparam int RADIUS_SQ_BITS = 2 * RADIUS_WIDTH;

   localparam logic [RADIUS_WIDTH-1:0]   RADIUS_RESET    = 16'd7168;
   localparam logic [RADIUS_SQ_BITS-1:0] RADIUS_SQ_RESET =
      RADIUS_SQ_BITS'(RADIUS_RESET) * RADIUS_SQ_BITS'(RADIUS_RESET);

   // outstanding transfer counter width in the checker
   localparam int TRACK_BITS = 8;

endpackage

// ===== rtl/mcsh_if.sv =====
// Valid/ready channel interfaces: request (twelve coordinates), response (hit)
// and the radius write channel. Depends on mcsh_pkg.
interface mcsh_req_if import mcsh_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] circle_last_x;
   logic signed [COORD_BITS-1:0] circle_last_y;
   logic signed [COORD_BITS-1:0] circle_now_x;
   logic signed [COORD_BITS-1:0] circle_now_y;
   logic signed [COORD_BITS-1:0] end_a_last_x;
   logic signed [COORD_BITS-1:0] end_a_last_y;
   logic signed [COORD_BITS-1:0] end_a_now_x;
   logic signed [COORD_BITS-1:0] end_a_now_y;
   logic signed [COORD_BITS-1:0] end_b_last_x;
   logic signed [COORD_BITS-1:0] end_b_last_y;
   logic signed [COORD_BITS-1:0] end_b_now_x;
   logic signed [COORD_BITS-1:0] end_b_now_y;

   modport source (
      output valid, circle_last_x, circle_last_y, circle_now_x, circle_now_y,
             end_a_last_x, end_a_last_y, end_a_now_x, end_a_now_y,
             end_b_last_x, end_b_last_y, end_b_now_x, end_b_now_y,
      input  ready
   );
   modport sink (
      input  valid, circle_last_x, circle_last_y, circle_now_x, circle_now_y,
             end_a_last_x, end_a_last_y, end_a_now_x, end_a_now_y,
             end_b_last_x, end_b_last_y, end_b_now_x, end_b_now_y,
      output ready
   );
endinterface

interface mcsh_rsp_if import mcsh_pkg::*; ();
   logic valid;
   logic ready;
   logic hit;

   modport source (output valid, hit, input ready);
   modport sink   (input valid, hit, output ready);
endinterface

interface mcsh_csr_if import mcsh_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [RADIUS_WIDTH-1:0] circle_radius;

   modport source (output valid, circle_radius, input ready);
   modport sink   (input valid, circle_radius, output ready);
endinterface

// ===== rtl/mcsh_div.sv =====
// Pipelined restoring fraction divider: one quotient bit per stage.
// Standalone; instantiated twice by moving_circle_segment_hit_core.
module mcsh_div #(
   parameter int W  = 8,
   parameter int F  = 8,
   parameter int PW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [W-1:0]  in_num,   // must be below in_den
   input  logic [W-1:0]  in_den,
   input  logic [PW-1:0] in_pay,
   output logic          out_valid,
   output logic [F-1:0]  out_quot,
   output logic [PW-1:0] out_pay
);

   logic [W-1:0]  rem_ff [F];
   logic [W-1:0]  den_ff [F];
   logic [F-1:0]  q_ff   [F];
   logic [PW-1:0] pay_ff [F];
   logic          vld_ff [F];

   for (genvar k = 0; k < F; k++) begin : g_step
      logic [W-1:0]  rem_src;
      logic [W-1:0]  den_src;
      logic [F-1:0]  q_src;
      logic [PW-1:0] pay_src;
      logic          v_src;
      logic [W:0]    rem_sh;
      logic [W:0]    rem_sub;
      logic          ge;
      logic [W-1:0]  rem_in;

      if (k == 0) begin : g_first
         assign rem_src = in_num;
         assign den_src = in_den;
         assign q_src   = '0;
         assign pay_src = in_pay;
         assign v_src   = in_valid;
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign den_src = den_ff[k-1];
         assign q_src   = q_ff[k-1];
         assign pay_src = pay_ff[k-1];
         assign v_src   = vld_ff[k-1];
      end

      assign rem_sh  = {rem_src, 1'b0};
      assign rem_sub = rem_sh - {1'b0, den_src};
      assign ge      = (rem_sh >= {1'b0, den_src});
      assign rem_in  = ge ? rem_sub[W-1:0] : rem_sh[W-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_src;
            q_ff[k]   <= {q_src[F-2:0], ge};
            pay_ff[k] <= pay_src;
         end
      end
   end

   assign out_valid = vld_ff[F-1];
   assign out_quot  = q_ff[F-1];
   assign out_pay   = pay_ff[F-1];

endmodule

// ===== rtl/moving_circle_segment_hit_core.sv =====
// Swept circle versus moving segment hit test, fully pipelined.
// Depends on mcsh_pkg, the channel interfaces in mcsh_if.sv and mcsh_div.
//
// One request transfer can be taken every clock while the output is not
// stalled. Each request passes two restoring dividers, one quotient bit per
// stage each (time of closest approach t, then segment parameter s), plus
// seventeen stages of split multiplies and wide adds. The response register
// is the last stage; when it holds an untaken result the whole pipeline
// holds, so req_chan.ready = !rsp_chan.valid || rsp_chan.ready. Results leave
// in request order. The radius write channel is always ready; write it only
// while no request is in flight. There is no clearing pass after reset.
module moving_circle_segment_hit_core
   import mcsh_pkg::*;
#(
   parameter int COORD_BITS      = COORD_BITS_DEFAULT,
   parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   mcsh_req_if.sink   req_chan,
   mcsh_rsp_if.source rsp_chan,
   mcsh_csr_if.sink   csr_chan
);

   localparam int C   = COORD_BITS;
   localparam int F   = PARAM_FRAC_BITS;
   localparam int WR  = C + 3;          // relative velocity, 9 frac bits
   localparam int WD  = C + 1;          // segment and offset vectors
   localparam int WA  = 2 * WR + 1;
   localparam int WB  = WR + WD + 1;
   localparam int WC  = 2 * WD + 1;
   localparam int LA  = WA / 2;
   localparam int HA  = WA - LA;
   localparam int LB  = WB / 2;
   localparam int HB  = WB - LB;
   localparam int LC  = WC / 2;
   localparam int HC  = WC - LC;
   localparam int WP  = WA + WC;
   localparam int WN  = WP + 1;
   localparam int WN1 = WN + 1;
   localparam int GW  = 2 * WR + 4 * WD;
   localparam int WT  = F + 1;
   localparam int WRT = WR + F + 2;
   localparam int WQ  = WR + F + 3;
   localparam int LQ  = WQ / 2;
   localparam int HQ  = WQ - LQ;
   localparam int WPJ = WQ + WD + 1;
   localparam int WS  = WC + F + 1;
   localparam int WDT = WD + F + 2;
   localparam int WE  = WQ + 1;
   localparam int LE  = WE / 2;
   localparam int HE  = WE - LE;
   localparam int WDS = 2 * WE + 1;
   localparam int WRR = RADIUS_SQ_BITS + 2 + 2 * F;
   localparam int WCMP = (WDS > WRR) ? WDS : WRR;
   localparam int PW1 = GW + WC + 1;
   localparam int PW2 = 2 * WQ + 2 * WD + 1;
   localparam logic [WT-1:0] ONE_T = WT'(1) << F;

   // global advance: output register empty or being drained
   logic en;
   assign en = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = en;

   // ---------------- radius register (kept squared) ----------------
   logic [RADIUS_SQ_BITS-1:0] rsq_ff, rsq_in;
   assign csr_chan.ready = 1'b1;
   assign rsq_in = RADIUS_SQ_BITS'(csr_chan.circle_radius) *
                   RADIUS_SQ_BITS'(csr_chan.circle_radius);
   always_ff @(posedge clock) begin
      if (reset) begin
         rsq_ff <= RADIUS_SQ_RESET;
      end else if (csr_chan.valid) begin
         rsq_ff <= rsq_in;
      end
   end

   // ---------------- valid chain ----------------
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff, s6_v_ff, s7_v_ff;
   logic t1_v_ff, t2_v_ff, t3_v_ff, t4_v_ff, t5_v_ff;
   logic u1_v_ff, u2_v_ff, u3_v_ff, u4_v_ff, u5_v_ff;
   logic d1_v, d2_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0; s2_v_ff <= 1'b0; s3_v_ff <= 1'b0; s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0; s6_v_ff <= 1'b0; s7_v_ff <= 1'b0;
         t1_v_ff <= 1'b0; t2_v_ff <= 1'b0; t3_v_ff <= 1'b0; t4_v_ff <= 1'b0;
         t5_v_ff <= 1'b0;
         u1_v_ff <= 1'b0; u2_v_ff <= 1'b0; u3_v_ff <= 1'b0; u4_v_ff <= 1'b0;
         u5_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_chan.valid;
         s2_v_ff <= s1_v_ff; s3_v_ff <= s2_v_ff; s4_v_ff <= s3_v_ff;
         s5_v_ff <= s4_v_ff; s6_v_ff <= s5_v_ff; s7_v_ff <= s6_v_ff;
         t1_v_ff <= d1_v;
         t2_v_ff <= t1_v_ff; t3_v_ff <= t2_v_ff; t4_v_ff <= t3_v_ff;
         t5_v_ff <= t4_v_ff;
         u1_v_ff <= d2_v;
         u2_v_ff <= u1_v_ff; u3_v_ff <= u2_v_ff; u4_v_ff <= u3_v_ff;
         u5_v_ff <= u4_v_ff;
      end
   end

   // ---------------- S1: difference vectors ----------------
   logic signed [WR-1:0] dcx, dcy, dax, day, dbx, dby, rx_in, ry_in;
   logic signed [WD-1:0] dx_in, dy_in, mx_in, my_in;
   logic [GW-1:0]        s1_geo_ff;

   always_comb begin
      dcx = WR'(req_chan.circle_now_x) - WR'(req_chan.circle_last_x);
      dcy = WR'(req_chan.circle_now_y) - WR'(req_chan.circle_last_y);
      dax = WR'(req_chan.end_a_now_x) - WR'(req_chan.end_a_last_x);
      day = WR'(req_chan.end_a_now_y) - WR'(req_chan.end_a_last_y);
      dbx = WR'(req_chan.end_b_now_x) - WR'(req_chan.end_b_last_x);
      dby = WR'(req_chan.end_b_now_y) - WR'(req_chan.end_b_last_y);
      // twice circle velocity minus the sum of end velocities
      rx_in = (dcx <<< 1) - (dax + dbx);
      ry_in = (dcy <<< 1) - (day + dby);
      dx_in = WD'(req_chan.end_b_last_x) - WD'(req_chan.end_a_last_x);
      dy_in = WD'(req_chan.end_b_last_y) - WD'(req_chan.end_a_last_y);
      mx_in = WD'(req_chan.circle_last_x) - WD'(req_chan.end_a_last_x);
      my_in = WD'(req_chan.circle_last_y) - WD'(req_chan.end_a_last_y);
   end

   logic signed [WR-1:0] s1_rx, s1_ry;
   logic signed [WD-1:0] s1_mx, s1_my, s1_dx, s1_dy;
   assign s1_rx = $signed(s1_geo_ff[GW-1 -: WR]);
   assign s1_ry = $signed(s1_geo_ff[GW-WR-1 -: WR]);
   assign s1_mx = $signed(s1_geo_ff[4*WD-1 -: WD]);
   assign s1_my = $signed(s1_geo_ff[3*WD-1 -: WD]);
   assign s1_dx = $signed(s1_geo_ff[2*WD-1 -: WD]);
   assign s1_dy = $signed(s1_geo_ff[WD-1:0]);

   // ---------------- S2: dot product terms ----------------
   logic signed [2*WR-1:0]  s2_aax_ff, s2_aay_ff;
   logic signed [WR+WD-1:0] s2_bx_ff, s2_by_ff, s2_dx1_ff, s2_dy1_ff;
   logic signed [2*WD-1:0]  s2_cx_ff, s2_cy_ff, s2_ex_ff, s2_ey_ff;
   logic [GW-1:0]           s2_geo_ff;

   // ---------------- S3: dot products ----------------
   logic signed [WA-1:0] s3_a_ff;
   logic signed [WB-1:0] s3_b_ff, s3_d_ff;
   logic signed [WC-1:0] s3_c_ff, s3_e_ff;
   logic [GW-1:0]        s3_geo_ff;

   // ---------------- S4: split partial products ----------------
   logic signed [HA+HC-1:0] ac_hh_ff;
   logic signed [HA+LC:0]   ac_hl_ff;
   logic signed [LA+HC:0]   ac_lh_ff;
   logic [LA+LC-1:0]        ac_ll_ff;
   logic signed [2*HB-1:0]  bb_hh_ff;
   logic signed [HB+LB:0]   bb_hl_ff;
   logic [2*LB-1:0]         bb_ll_ff;
   logic signed [HB+HC-1:0] be_hh_ff;
   logic signed [HB+LC:0]   be_hl_ff;
   logic signed [LB+HC:0]   be_lh_ff;
   logic [LB+LC-1:0]        be_ll_ff;
   logic signed [HC+HB-1:0] cd_hh_ff;
   logic signed [HC+LB:0]   cd_hl_ff;
   logic signed [LC+HB:0]   cd_lh_ff;
   logic [LC+LB-1:0]        cd_ll_ff;
   logic signed [WC-1:0]    s4_c_ff;
   logic [GW-1:0]           s4_geo_ff;

   // ---------------- S5/S6/S7 ----------------
   logic signed [WP-1:0] s5_ac_ff, s5_bb_ff, s5_be_ff, s5_cd_ff;
   logic signed [WP-1:0] ac_in, bb_in, be_in, cd_in;
   logic signed [WC-1:0] s5_c_ff, s6_c_ff, s7_c_ff;
   logic [GW-1:0]        s5_geo_ff, s6_geo_ff, s7_geo_ff;
   logic signed [WN-1:0] s6_den_ff, s6_num_ff;
   logic signed [WN1-1:0] num2;
   logic                 zero_t, full_t;
   logic [WN-1:0]        s7_num_ff, s7_den_ff, t_num_in, t_den_in;
   logic                 s7_full_ff;

   always_comb begin
      ac_in = (WP'(ac_hh_ff) <<< (LA + LC)) + (WP'(ac_hl_ff) <<< LA) +
              (WP'(ac_lh_ff) <<< LC) + WP'($signed({1'b0, ac_ll_ff}));
      bb_in = (WP'(bb_hh_ff) <<< (2 * LB)) + (WP'(bb_hl_ff) <<< (LB + 1)) +
              WP'($signed({1'b0, bb_ll_ff}));
      be_in = (WP'(be_hh_ff) <<< (LB + LC)) + (WP'(be_hl_ff) <<< LB) +
              (WP'(be_lh_ff) <<< LC) + WP'($signed({1'b0, be_ll_ff}));
      cd_in = (WP'(cd_hh_ff) <<< (LC + LB)) + (WP'(cd_hl_ff) <<< LC) +
              (WP'(cd_lh_ff) <<< LB) + WP'($signed({1'b0, cd_ll_ff}));
   end

   // t = clamp(2*num/den); parallel motion or a receding path gives t = 0
   always_comb begin
      num2     = WN1'(s6_num_ff) <<< 1;
      zero_t   = (s6_den_ff == '0) || s6_num_ff[WN-1] || (s6_num_ff == '0);
      full_t   = !zero_t && (num2 >= WN1'(s6_den_ff));
      t_num_in = (zero_t || full_t) ? '0 : num2[WN-1:0];
      t_den_in = zero_t ? WN'(1) : s6_den_ff[WN-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_geo_ff <= {rx_in, ry_in, mx_in, my_in, dx_in, dy_in};

         s2_aax_ff <= s1_rx * s1_rx;
         s2_aay_ff <= s1_ry * s1_ry;
         s2_bx_ff  <= s1_rx * s1_dx;
         s2_by_ff  <= s1_ry * s1_dy;
         s2_cx_ff  <= s1_dx * s1_dx;
         s2_cy_ff  <= s1_dy * s1_dy;
         s2_dx1_ff <= s1_rx * s1_mx;
         s2_dy1_ff <= s1_ry * s1_my;
         s2_ex_ff  <= s1_dx * s1_mx;
         s2_ey_ff  <= s1_dy * s1_my;
         s2_geo_ff <= s1_geo_ff;

         s3_a_ff   <= WA'(s2_aax_ff) + WA'(s2_aay_ff);
         s3_b_ff   <= WB'(s2_bx_ff) + WB'(s2_by_ff);
         s3_c_ff   <= WC'(s2_cx_ff) + WC'(s2_cy_ff);
         s3_d_ff   <= WB'(s2_dx1_ff) + WB'(s2_dy1_ff);
         s3_e_ff   <= WC'(s2_ex_ff) + WC'(s2_ey_ff);
         s3_geo_ff <= s2_geo_ff;

         ac_hh_ff <= $signed(s3_a_ff[WA-1:LA]) * $signed(s3_c_ff[WC-1:LC]);
         ac_hl_ff <= $signed(s3_a_ff[WA-1:LA]) * $signed({1'b0, s3_c_ff[LC-1:0]});
         ac_lh_ff <= $signed({1'b0, s3_a_ff[LA-1:0]}) * $signed(s3_c_ff[WC-1:LC]);
         ac_ll_ff <= s3_a_ff[LA-1:0] * s3_c_ff[LC-1:0];
         bb_hh_ff <= $signed(s3_b_ff[WB-1:LB]) * $signed(s3_b_ff[WB-1:LB]);
         bb_hl_ff <= $signed(s3_b_ff[WB-1:LB]) * $signed({1'b0, s3_b_ff[LB-1:0]});
         bb_ll_ff <= s3_b_ff[LB-1:0] * s3_b_ff[LB-1:0];
         be_hh_ff <= $signed(s3_b_ff[WB-1:LB]) * $signed(s3_e_ff[WC-1:LC]);
         be_hl_ff <= $signed(s3_b_ff[WB-1:LB]) * $signed({1'b0, s3_e_ff[LC-1:0]});
         be_lh_ff <= $signed({1'b0, s3_b_ff[LB-1:0]}) * $signed(s3_e_ff[WC-1:LC]);
         be_ll_ff <= s3_b_ff[LB-1:0] * s3_e_ff[LC-1:0];
         cd_hh_ff <= $signed(s3_c_ff[WC-1:LC]) * $signed(s3_d_ff[WB-1:LB]);
         cd_hl_ff <= $signed(s3_c_ff[WC-1:LC]) * $signed({1'b0, s3_d_ff[LB-1:0]});
         cd_lh_ff <= $signed({1'b0, s3_c_ff[LC-1:0]}) * $signed(s3_d_ff[WB-1:LB]);
         cd_ll_ff <= s3_c_ff[LC-1:0] * s3_d_ff[LB-1:0];
         s4_c_ff   <= s3_c_ff;
         s4_geo_ff <= s3_geo_ff;

         s5_ac_ff  <= ac_in;
         s5_bb_ff  <= bb_in;
         s5_be_ff  <= be_in;
         s5_cd_ff  <= cd_in;
         s5_c_ff   <= s4_c_ff;
         s5_geo_ff <= s4_geo_ff;

         s6_den_ff <= WN'(s5_ac_ff) - WN'(s5_bb_ff);
         s6_num_ff <= WN'(s5_be_ff) - WN'(s5_cd_ff);
         s6_c_ff   <= s5_c_ff;
         s6_geo_ff <= s5_geo_ff;

         s7_num_ff  <= t_num_in;
         s7_den_ff  <= t_den_in;
         s7_full_ff <= full_t;
         s7_c_ff    <= s6_c_ff;
         s7_geo_ff  <= s6_geo_ff;
      end
   end

   // ---------------- divider for t ----------------
   logic [F-1:0]   d1_q;
   logic [PW1-1:0] d1_pay;

   mcsh_div #(.W(WN), .F(F), .PW(PW1)) u_div_t (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s7_v_ff),
      .in_num    (s7_num_ff),
      .in_den    (s7_den_ff),
      .in_pay    ({s7_geo_ff, s7_c_ff, s7_full_ff}),
      .out_valid (d1_v),
      .out_quot  (d1_q),
      .out_pay   (d1_pay)
   );

   logic [GW-1:0]        d1_geo;
   logic signed [WR-1:0] d1_rx, d1_ry;
   logic [WT-1:0]        t_val;
   assign d1_geo = d1_pay[PW1-1 -: GW];
   assign d1_rx  = $signed(d1_geo[GW-1 -: WR]);
   assign d1_ry  = $signed(d1_geo[GW-WR-1 -: WR]);
   assign t_val  = d1_pay[0] ? ONE_T : {1'b0, d1_q};

   // ---------------- T stages: path point and projection ----------------
   logic signed [WRT-1:0]   t1_prx_ff, t1_pry_ff;
   logic signed [WD-1:0]    t1_mx_ff, t1_my_ff, t1_dx_ff, t1_dy_ff;
   logic signed [WC-1:0]    t1_c_ff, t2_c_ff, t3_c_ff, t4_c_ff;
   logic signed [WQ-1:0]    t2_qx_ff, t2_qy_ff, t3_qx_ff, t3_qy_ff;
   logic signed [WQ-1:0]    t4_qx_ff, t4_qy_ff, t5_qx_ff, t5_qy_ff;
   logic signed [WD-1:0]    t2_dx_ff, t2_dy_ff, t3_dx_ff, t3_dy_ff;
   logic signed [WD-1:0]    t4_dx_ff, t4_dy_ff, t5_dx_ff, t5_dy_ff;
   logic signed [HQ+WD-1:0] t3_xh_ff, t3_yh_ff;
   logic signed [LQ+WD:0]   t3_xl_ff, t3_yl_ff;
   logic signed [WPJ-1:0]   t4_proj_ff, proj_in;
   logic [WS-1:0]           den2, s_num_in, s_den_in, t5_num_ff, t5_den_ff;
   logic                    zero_s, full_s, t5_full_ff;

   assign proj_in = (WPJ'(t3_xh_ff) <<< LQ) + WPJ'(t3_xl_ff) +
                    (WPJ'(t3_yh_ff) <<< LQ) + WPJ'(t3_yl_ff);

   // s = clamp(proj / (c << (F+1))); a degenerate segment gives s = 0
   always_comb begin
      den2     = {t4_c_ff[WC-1:0], (F + 1)'(0)};
      zero_s   = (t4_c_ff == '0) || t4_proj_ff[WPJ-1] || (t4_proj_ff == '0);
      full_s   = !zero_s && ($unsigned(t4_proj_ff) >= WPJ'(den2));
      s_num_in = (zero_s || full_s) ? '0 : t4_proj_ff[WS-1:0];
      s_den_in = zero_s ? WS'(1) : den2;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t1_prx_ff <= d1_rx * $signed({1'b0, t_val});
         t1_pry_ff <= d1_ry * $signed({1'b0, t_val});
         t1_mx_ff  <= $signed(d1_geo[4*WD-1 -: WD]);
         t1_my_ff  <= $signed(d1_geo[3*WD-1 -: WD]);
         t1_dx_ff  <= $signed(d1_geo[2*WD-1 -: WD]);
         t1_dy_ff  <= $signed(d1_geo[WD-1:0]);
         t1_c_ff   <= $signed(d1_pay[WC:1]);

         t2_qx_ff <= (WQ'(t1_mx_ff) <<< (F + 1)) + WQ'(t1_prx_ff);
         t2_qy_ff <= (WQ'(t1_my_ff) <<< (F + 1)) + WQ'(t1_pry_ff);
         t2_dx_ff <= t1_dx_ff;
         t2_dy_ff <= t1_dy_ff;
         t2_c_ff  <= t1_c_ff;

         t3_xh_ff <= $signed(t2_qx_ff[WQ-1:LQ]) * t2_dx_ff;
         t3_xl_ff <= $signed({1'b0, t2_qx_ff[LQ-1:0]}) * t2_dx_ff;
         t3_yh_ff <= $signed(t2_qy_ff[WQ-1:LQ]) * t2_dy_ff;
         t3_yl_ff <= $signed({1'b0, t2_qy_ff[LQ-1:0]}) * t2_dy_ff;
         t3_qx_ff <= t2_qx_ff;
         t3_qy_ff <= t2_qy_ff;
         t3_dx_ff <= t2_dx_ff;
         t3_dy_ff <= t2_dy_ff;
         t3_c_ff  <= t2_c_ff;

         t4_proj_ff <= proj_in;
         t4_qx_ff   <= t3_qx_ff;
         t4_qy_ff   <= t3_qy_ff;
         t4_dx_ff   <= t3_dx_ff;
         t4_dy_ff   <= t3_dy_ff;
         t4_c_ff    <= t3_c_ff;

         t5_num_ff  <= s_num_in;
         t5_den_ff  <= s_den_in;
         t5_full_ff <= full_s;
         t5_qx_ff   <= t4_qx_ff;
         t5_qy_ff   <= t4_qy_ff;
         t5_dx_ff   <= t4_dx_ff;
         t5_dy_ff   <= t4_dy_ff;
      end
   end

   // ---------------- divider for s ----------------
   logic [F-1:0]   d2_q;
   logic [PW2-1:0] d2_pay;

   mcsh_div #(.W(WS), .F(F), .PW(PW2)) u_div_s (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (t5_v_ff),
      .in_num    (t5_num_ff),
      .in_den    (t5_den_ff),
      .in_pay    ({t5_qx_ff, t5_qy_ff, t5_dx_ff, t5_dy_ff, t5_full_ff}),
      .out_valid (d2_v),
      .out_quot  (d2_q),
      .out_pay   (d2_pay)
   );

   logic [WT-1:0] s_val;
   assign s_val = d2_pay[0] ? ONE_T : {1'b0, d2_q};

   // ---------------- U stages: distance and compare ----------------
   logic signed [WDT-1:0]     u1_pdx_ff, u1_pdy_ff;
   logic signed [WQ-1:0]      u1_qx_ff, u1_qy_ff;
   logic signed [WE-1:0]      u2_ex_ff, u2_ey_ff;
   logic signed [2*HE-1:0]    u3_xhh_ff, u3_yhh_ff;
   logic signed [HE+LE:0]     u3_xhl_ff, u3_yhl_ff;
   logic [2*LE-1:0]           u3_xll_ff, u3_yll_ff;
   logic signed [WDS-1:0]     u4_dist_ff, dist_in;
   logic [WCMP-1:0]           dist_u, rr_u;
   logic                      hit_ff;

   assign dist_in = (WDS'(u3_xhh_ff) <<< (2 * LE)) + (WDS'(u3_xhl_ff) <<< (LE + 1)) +
                    WDS'($signed({1'b0, u3_xll_ff})) +
                    (WDS'(u3_yhh_ff) <<< (2 * LE)) + (WDS'(u3_yhl_ff) <<< (LE + 1)) +
                    WDS'($signed({1'b0, u3_yll_ff}));

   // squared distance is never negative; compare against r*r scaled to match
   assign dist_u = WCMP'($unsigned(u4_dist_ff));
   assign rr_u   = WCMP'(rsq_ff) << (2 + 2 * F);

   always_ff @(posedge clock) begin
      if (en) begin
         u1_pdx_ff <= $signed(d2_pay[2*WD:WD+1]) * $signed({1'b0, s_val});
         u1_pdy_ff <= $signed(d2_pay[WD:1]) * $signed({1'b0, s_val});
         u1_qx_ff  <= $signed(d2_pay[PW2-1 -: WQ]);
         u1_qy_ff  <= $signed(d2_pay[PW2-WQ-1 -: WQ]);

         u2_ex_ff <= WE'(u1_qx_ff) - (WE'(u1_pdx_ff) <<< 1);
         u2_ey_ff <= WE'(u1_qy_ff) - (WE'(u1_pdy_ff) <<< 1);

         u3_xhh_ff <= $signed(u2_ex_ff[WE-1:LE]) * $signed(u2_ex_ff[WE-1:LE]);
         u3_xhl_ff <= $signed(u2_ex_ff[WE-1:LE]) * $signed({1'b0, u2_ex_ff[LE-1:0]});
         u3_xll_ff <= u2_ex_ff[LE-1:0] * u2_ex_ff[LE-1:0];
         u3_yhh_ff <= $signed(u2_ey_ff[WE-1:LE]) * $signed(u2_ey_ff[WE-1:LE]);
         u3_yhl_ff <= $signed(u2_ey_ff[WE-1:LE]) * $signed({1'b0, u2_ey_ff[LE-1:0]});
         u3_yll_ff <= u2_ey_ff[LE-1:0] * u2_ey_ff[LE-1:0];

         u4_dist_ff <= dist_in;

         hit_ff <= (dist_u <= rr_u);
      end
   end

   assign rsp_chan.valid = u5_v_ff;
   assign rsp_chan.hit   = hit_ff;

endmodule

// ===== rtl/mcsh_checker.sv =====
// Port-level checker for moving_circle_segment_hit_core, attached by bind.
// Depends on mcsh_pkg and the core's channel interfaces.
module mcsh_checker
   import mcsh_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_hit
);

   logic [TRACK_BITS-1:0] cnt_ff, cnt_in;
   logic                  req_xfer, rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   always_comb begin
      cnt_in = cnt_ff;
      if (req_xfer && !rsp_xfer) begin
         cnt_in = cnt_ff + TRACK_BITS'(1);
      end else if (!req_xfer && rsp_xfer) begin
         cnt_in = cnt_ff - TRACK_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_hit))
      else $error("response changed while stalled");

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while output stalled");

   a_free_takes_req: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused with empty output");

   a_no_extra_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer |-> cnt_ff != '0)
      else $error("response without a pending request");

endmodule

bind moving_circle_segment_hit_core mcsh_checker u_mcsh_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_hit   (rsp_chan.hit)
);

// ===== verif/mcsh_hit_checker.sv =====
// Checker for moving_circle_segment_hit_core: watches the request, response and
// radius channels, predicts each hit in exact integer math and compares in order.
// Depends on mcsh_pkg and the channel interfaces in mcsh_if.sv.
`timescale 1ns / 100ps
module mcsh_hit_checker
   import mcsh_pkg::*;
#(
   parameter int COORD_BITS      = COORD_BITS_DEFAULT,
   parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEFAULT
) (
   input logic  clock,
   input logic  reset,
   mcsh_req_if  req_chan,
   mcsh_rsp_if  rsp_chan,
   mcsh_csr_if  csr_chan,
   output int   error_count,
   output int   pending_count,
   output int   hit_total,
   output int   result_total
);
   typedef logic signed [255:0] wide_t;
   typedef logic signed [COORD_BITS-1:0] coord_t;

   logic [RADIUS_WIDTH-1:0] radius_shadow;
   bit pending_hits[$];

   // floor(num * 2^F / den) clamped to [0, 2^F], den > 0
   function automatic longint unsigned frac_quot(wide_t num, wide_t den);
      wide_t q;
      if (num <= 0) return 0;
      if (num >= den) return longint'(1) << PARAM_FRAC_BITS;
      q = (num <<< PARAM_FRAC_BITS) / den;
      return longint'(q);
   endfunction

   function automatic bit predict_hit(coord_t clx, coord_t cly, coord_t cnx, coord_t cny,
                                      coord_t alx, coord_t aly, coord_t anx, coord_t any_,
                                      coord_t blx, coord_t bly, coord_t bnx, coord_t bny,
                                      logic [RADIUS_WIDTH-1:0] radius);
      wide_t rx, ry, dx, dy, mx, my, a, b, c, d1, e, den, num, tq, sq, qx, qy, ex, ey;
      wide_t dist_sq, rr;
      rx = 2 * (wide_t'(cnx) - wide_t'(clx)) - ((wide_t'(anx) - wide_t'(alx))
           + (wide_t'(bnx) - wide_t'(blx)));
      ry = 2 * (wide_t'(cny) - wide_t'(cly)) - ((wide_t'(any_) - wide_t'(aly))
           + (wide_t'(bny) - wide_t'(bly)));
      dx = wide_t'(blx) - wide_t'(alx);
      dy = wide_t'(bly) - wide_t'(aly);
      mx = wide_t'(clx) - wide_t'(alx);
      my = wide_t'(cly) - wide_t'(aly);
      a  = rx * rx + ry * ry;
      b  = rx * dx + ry * dy;
      c  = dx * dx + dy * dy;
      d1 = rx * mx + ry * my;
      e  = dx * mx + dy * my;
      den = a * c - b * b;
      num = b * e - c * d1;
      // parallel or stationary motion: t stays zero
      tq = (den == 0) ? 0 : wide_t'(frac_quot(num <<< 1, den));
      qx = (mx <<< (1 + PARAM_FRAC_BITS)) + rx * tq;
      qy = (my <<< (1 + PARAM_FRAC_BITS)) + ry * tq;
      // degenerate segment: s stays zero
      sq = (c == 0) ? 0 : wide_t'(frac_quot(qx * dx + qy * dy, c <<< (1 + PARAM_FRAC_BITS)));
      ex = qx - 2 * dx * sq;
      ey = qy - 2 * dy * sq;
      dist_sq = ex * ex + ey * ey;
      rr = (wide_t'(radius) * wide_t'(radius)) <<< (2 + 2 * PARAM_FRAC_BITS);
      return dist_sq <= rr;
   endfunction

   assign pending_count = pending_hits.size();

   always @(posedge clock) begin
      bit want;
      if (reset) begin
         radius_shadow <= RADIUS_RESET;
         pending_hits.delete();
         error_count  <= 0;
         hit_total    <= 0;
         result_total <= 0;
      end else begin
         if (csr_chan.valid && csr_chan.ready) radius_shadow <= csr_chan.circle_radius;
         if (req_chan.valid && req_chan.ready)
            pending_hits.push_back(predict_hit(req_chan.circle_last_x, req_chan.circle_last_y,
               req_chan.circle_now_x, req_chan.circle_now_y, req_chan.end_a_last_x,
               req_chan.end_a_last_y, req_chan.end_a_now_x, req_chan.end_a_now_y,
               req_chan.end_b_last_x, req_chan.end_b_last_y, req_chan.end_b_now_x,
               req_chan.end_b_now_y, radius_shadow));
         if (rsp_chan.valid && rsp_chan.ready) begin
            result_total <= result_total + 1;
            hit_total    <= hit_total + (rsp_chan.hit === 1'b1);
            if (pending_hits.size() == 0) begin
               if (error_count < 10) $display("unexpected hit transfer: hit=%b", rsp_chan.hit);
               error_count <= error_count + 1;
            end else begin
               want = pending_hits.pop_front();
               if (rsp_chan.hit !== want) begin
                  if (error_count < 10)
                     $display("hit mismatch #%0d: expected %b, got %b",
                              result_total, want, rsp_chan.hit);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end
endmodule

// ===== verif/tb_moving_circle_segment_hit_core.sv =====
// Top of the hit core testbench: clock, reset, radius writes, request
// stimulus and the verdict. Depends on mcsh_pkg, mcsh_if.sv and the checker.
`timescale 1ns / 100ps
module tb_moving_circle_segment_hit_core;
   import mcsh_pkg::*;

   localparam int CB       = COORD_BITS_DEFAULT;
   localparam int LATENCY  = 2 * PARAM_FRAC_BITS_DEFAULT + 17;
   localparam int N_RANDOM = 950;
   localparam longint CYCLE_LIMIT = 400000;

   typedef logic signed [CB-1:0] coord_t;
   localparam coord_t C_MAX = {1'b0, {(CB-1){1'b1}}};
   localparam coord_t C_MIN = {1'b1, {(CB-1){1'b0}}};

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   error_count, pending_count, hit_total, result_total;
   longint cycle_count = 0;
   int   idle_pct = 20;     // 0 during the quiet stretch
   int   sent = 0;

   mcsh_req_if #(.COORD_BITS(CB)) req_chan ();
   mcsh_rsp_if rsp_chan ();
   mcsh_csr_if csr_chan ();

   moving_circle_segment_hit_core dut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source), .csr_chan(csr_chan.sink)
   );

   mcsh_hit_checker #(.COORD_BITS(CB)) u_checker (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_chan(csr_chan), .error_count(error_count), .pending_count(pending_count),
      .hit_total(hit_total), .result_total(result_total)
   );

   always #5 clock = ~clock;

   // response side stalls at random
   initial rsp_chan.ready = 1'b0;
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= idle_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   coord_t item [12];

   function automatic coord_t rnd_coord(int mag);
      // mag selects small, moderate or full-range values
      case (mag)
         0: return coord_t'($signed($urandom_range(4095)) - 2048);
         1: return coord_t'($signed($urandom_range(262143)) - 131072);
         default: return coord_t'($urandom);
      endcase
   endfunction

   // one request transfer; valid stays high into the next item unless an idle gap comes
   task automatic send_item();
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.circle_last_x <= item[0];  req_chan.circle_last_y <= item[1];
      req_chan.circle_now_x  <= item[2];  req_chan.circle_now_y  <= item[3];
      req_chan.end_a_last_x  <= item[4];  req_chan.end_a_last_y  <= item[5];
      req_chan.end_a_now_x   <= item[6];  req_chan.end_a_now_y   <= item[7];
      req_chan.end_b_last_x  <= item[8];  req_chan.end_b_last_y  <= item[9];
      req_chan.end_b_now_x   <= item[10]; req_chan.end_b_now_y   <= item[11];
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent++;
   endtask

   // radius writes only with the pipe drained
   task automatic write_radius(logic [RADIUS_WIDTH-1:0] r);
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      csr_chan.valid         <= 1'b1;
      csr_chan.circle_radius <= r;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic fill_all(coord_t v);
      foreach (item[i]) item[i] = v;
   endtask

   // random scene near a touching configuration so hits and misses both occur
   task automatic random_scene(int mag);
      coord_t base_x, base_y;
      base_x = rnd_coord(mag);
      base_y = rnd_coord(mag);
      foreach (item[i]) item[i] = (i % 2 == 0) ? base_x + rnd_coord(mag > 0 ? mag - 1 : 0)
                                               : base_y + rnd_coord(mag > 0 ? mag - 1 : 0);
      if ($urandom_range(9) == 0) begin
         item[8] = item[4]; item[9] = item[5];            // degenerate segment
      end
      if ($urandom_range(9) == 0) begin
         item[2] = item[0]; item[3] = item[1];            // no relative motion
         item[6] = item[4]; item[7] = item[5];
         item[10] = item[8]; item[11] = item[9];
      end
   endtask

   initial begin
      req_chan.valid = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.circle_radius = '0;
      req_chan.circle_last_x = '0; req_chan.circle_last_y = '0;
      req_chan.circle_now_x  = '0; req_chan.circle_now_y  = '0;
      req_chan.end_a_last_x  = '0; req_chan.end_a_last_y  = '0;
      req_chan.end_a_now_x   = '0; req_chan.end_a_now_y   = '0;
      req_chan.end_b_last_x  = '0; req_chan.end_b_last_y  = '0;
      req_chan.end_b_now_x   = '0; req_chan.end_b_now_y   = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset radius, extremes, stationary and degenerate cases
      fill_all('0);                                     send_item();
      fill_all(C_MAX);                                  send_item();
      fill_all(C_MIN);                                  send_item();
      foreach (item[i]) item[i] = (i % 2) ? C_MAX : C_MIN; send_item();
      foreach (item[i]) item[i] = (i % 2) ? C_MIN : C_MAX; send_item();
      foreach (item[i]) item[i] = (i < 4) ? C_MAX : C_MIN; send_item();
      foreach (item[i]) item[i] = (i < 4) ? C_MIN : C_MAX; send_item();
      // segment from (0,0) to (100,0), circle crossing it
      fill_all('0); item[8] = 25600; item[10] = 25600;
      item[1] = -2560; item[3] = 2560;                    send_item();
      // parallel motion: everything moves by the same step
      fill_all('0); item[8] = 25600; item[1] = 5000;
      foreach (item[i]) if (i % 4 >= 2) item[i] = item[i-2] + 300; send_item();
      // degenerate segment, circle just in / out of range of 28.0
      fill_all('0); item[0] = 7168; item[2] = 7168;       send_item();
      fill_all('0); item[0] = 7169; item[2] = 7169;       send_item();
      // circle passing the segment end beyond s=1
      fill_all('0); item[8] = 2560; item[10] = 2560;
      item[0] = 12000; item[1] = -9000; item[2] = 12000; item[3] = 9000; send_item();

      write_radius('0);
      fill_all('0); send_item();
      fill_all('0); item[0] = 1; item[2] = 1; send_item();
      write_radius(16'hFFFF);
      fill_all('0); item[0] = C_MAX; item[2] = C_MAX; send_item();
      fill_all(C_MIN); item[0] = C_MAX; send_item();

      // random phases with different radii; one quiet stretch with no idling
      for (int phase = 0; phase < 5; phase++) begin
         if (phase > 0) write_radius(phase == 4 ? 16'd1 : 16'($urandom));
         idle_pct = (phase == 2) ? 0 : 20;
         for (int n = 0; n < N_RANDOM / 5; n++) begin
            case ($urandom_range(9))
               0:       foreach (item[i]) item[i] = rnd_coord(2);
               1, 2, 3: random_scene(0);
               4, 5, 6: random_scene(1);
               default: random_scene(2);
            endcase
            send_item();
         end
      end
      idle_pct = 20;
      req_chan.valid <= 1'b0;
      @(posedge clock);

      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      $display("sent %0d requests, checked %0d results, %0d hits, across seven radius settings",
               sent, result_total, hit_total);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/mcsh_pkg.sv
rtl/mcsh_if.sv
rtl/mcsh_div.sv
rtl/moving_circle_segment_hit_core.sv
rtl/mcsh_checker.sv
verif/mcsh_hit_checker.sv
verif/tb_moving_circle_segment_hit_core.sv
